### design/dtbm_pkg.sv
// ----------------------------------------------------------------------------
// dtbm_pkg
// Shared types and constants of the dual token bucket meter.
// ----------------------------------------------------------------------------
package dtbm_pkg;

    localparam int LEN_W      = 19;
    localparam int MEAN_W     = 32;
    localparam int PEAK_W     = 19;
    localparam int RATE_W     = 32;
    localparam int WARMUP_W   = 48;
    localparam int PKT_CNT_W  = 32;
    localparam int BIT_CNT_W  = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // refill clamped just above any bucket cap
    localparam int REFILL_W = 33;
    localparam logic [REFILL_W-1:0] REFILL_CLAMP = {1'b1, {(REFILL_W-1){1'b0}}};

    localparam logic [MEAN_W-1:0] MEAN_SIZE_RESET = '0;
    localparam logic [PEAK_W-1:0] MTU_RESET       = PEAK_W'(12000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUCKET_SIZE = 3'd0,
        CFG_MEAN_RATE   = 3'd1,
        CFG_MTU         = 3'd2,
        CFG_PEAK_RATE   = 3'd3,
        CFG_WARMUP      = 3'd4
    } t_cfg_idx;

    // load enables of the three refill pipeline stages
    typedef struct packed {
        logic ld_prod;
        logic ld_sum;
        logic ld_out;
    } t_refill_ctrl;

endpackage

### design/dtbm_refill.sv
// ----------------------------------------------------------------------------
// dtbm_refill
// Three-stage refill pipeline: ceil(rate * elapsed / 2^F), clamped.
// ----------------------------------------------------------------------------
module dtbm_refill #(
    parameter int RATE_FRACTION_BITS = 16,
    parameter int TIME_WIDTH         = 48
) (
    input  logic                               i_clk,
    input  dtbm_pkg::t_refill_ctrl             i_ctrl,
    input  logic [dtbm_pkg::RATE_W-1:0]        i_rate,
    input  logic [TIME_WIDTH-1:0]              i_elapsed,
    output logic [dtbm_pkg::REFILL_W-1:0]      o_refill
);
    import dtbm_pkg::*;

    localparam logic [63:0] FRAC_MASK = (64'd1 << RATE_FRACTION_BITS) - 64'd1;

    logic [63:0] elapsed_64;
    logic [63:0] r_p_lo;
    logic [63:0] r_p_hi;
    logic [63:0] r_s;
    logic        r_sat;
    logic [64:0] n_s;
    logic [63:0] q_base;
    logic [64:0] q;
    logic        big;

    assign elapsed_64 = 64'(i_elapsed);

    // split the 32 x 64 product into two 32 x 32 halves
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_prod) begin
            r_p_lo <= 64'(i_rate) * 64'(elapsed_64[31:0]);
            r_p_hi <= 64'(i_rate) * 64'(elapsed_64[63:32]);
        end
    end

    assign n_s = {1'b0, r_p_hi[31:0], 32'd0} + {1'b0, r_p_lo};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_sum) begin
            r_s   <= n_s[63:0];
            r_sat <= (|r_p_hi[63:32]) | n_s[64];
        end
    end

    // round up on any fraction bits left over
    assign q_base = r_s >> RATE_FRACTION_BITS;
    assign q      = {1'b0, q_base} + 65'(|(r_s & FRAC_MASK));
    assign big    = r_sat | (|q[64:REFILL_W-1]);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_out) begin
            o_refill <= big ? REFILL_CLAMP : {1'b0, q[REFILL_W-2:0]};
        end
    end

endmodule

### design/dual_token_bucket_meter.sv
// ----------------------------------------------------------------------------
// dual_token_bucket_meter
// Mean-rate and peak-rate token bucket policer with warmup-gated counters.
// ----------------------------------------------------------------------------
// One packet word is accepted per cycle while results are taken; its verdict
// goes through the elapsed-time register, the split 32 x 32 multiply, the
// product sum, rounding and clamp, then the bucket update that feeds the next
// packet. The pipeline stalls only behind a result that is not taken, and
// empty stages close up so input keeps flowing while a result waits. Bucket
// levels and counters on the result ports are the live state after that
// packet. The configuration port is always ready; write it only while no
// packet is in flight. Writing a bucket capacity refills that bucket.
module dual_token_bucket_meter #(
    parameter int RATE_FRACTION_BITS = 16,
    parameter int TIME_WIDTH         = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dtbm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dtbm_pkg::CFG_DATA_W-1:0]       i_cfg_data,

    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [dtbm_pkg::LEN_W-1:0]            i_packet_length_bits,
    input  logic [TIME_WIDTH-1:0]                 i_arrival_time,

    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_not_conformed,
    output logic [dtbm_pkg::MEAN_W-1:0]           o_mean_bucket_level,
    output logic [dtbm_pkg::PEAK_W-1:0]           o_peak_bucket_level,
    output logic [dtbm_pkg::PKT_CNT_W-1:0]        o_packets_metered,
    output logic [dtbm_pkg::PKT_CNT_W-1:0]        o_packets_conformed,
    output logic [dtbm_pkg::BIT_CNT_W-1:0]        o_bits_metered,
    output logic [dtbm_pkg::BIT_CNT_W-1:0]        o_bits_conformed
);
    import dtbm_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > WARMUP_W) ? TIME_WIDTH : WARMUP_W;

    // configuration
    logic [MEAN_W-1:0]   r_bucket_size;
    logic [RATE_W-1:0]   r_mean_rate;
    logic [PEAK_W-1:0]   r_mtu;
    logic [RATE_W-1:0]   r_peak_rate;
    logic [WARMUP_W-1:0] r_warmup;

    // state
    logic [MEAN_W-1:0]    r_mean_tokens, n_mean_tokens;
    logic [PEAK_W-1:0]    r_peak_tokens, n_peak_tokens;
    logic [TIME_WIDTH-1:0] r_prev_time;
    logic                 r_warm_done, n_warm_done;
    logic [PKT_CNT_W-1:0] r_pkt_metered, n_pkt_metered;
    logic [PKT_CNT_W-1:0] r_pkt_conformed, n_pkt_conformed;
    logic [BIT_CNT_W-1:0] r_bit_metered, n_bit_metered;
    logic [BIT_CNT_W-1:0] r_bit_conformed, n_bit_conformed;
    logic                 r_not_conformed, n_not_conformed;

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic rdy_o, rdy4, rdy3, rdy2, rdy1;
    logic accept, ld2, ld3, ld4, ldo;
    logic cfg_we;
    t_refill_ctrl refill_ctrl;

    // pipeline payload
    logic [TIME_WIDTH-1:0] r_elapsed;
    logic [LEN_W-1:0]      r_len1, r_len2, r_len3, r_len4;
    logic                  r_ge1, r_ge2, r_ge3, r_ge4;
    logic [TIME_WIDTH-1:0] n_elapsed;
    logic                  n_ge;
    logic [REFILL_W-1:0]   mean_refill, peak_refill;

    // bucket update
    logic [REFILL_W:0]   mean_sum, peak_sum;
    logic [MEAN_W-1:0]   mean_filled;
    logic [PEAK_W-1:0]   peak_filled;
    logic                conform;
    logic [BIT_CNT_W:0]  bit_metered_sum, bit_conformed_sum;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // stall chain: a stage moves on when the next one is empty or moving
    assign rdy_o = !r_out_valid || i_out_ready;
    assign rdy4  = !r_v4 || rdy_o;
    assign rdy3  = !r_v3 || rdy4;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;

    assign o_in_ready = rdy1;
    assign accept     = i_in_valid && rdy1;
    assign ld2        = r_v1 && rdy2;
    assign ld3        = r_v2 && rdy3;
    assign ld4        = r_v3 && rdy4;
    assign ldo        = r_v4 && rdy_o;

    assign refill_ctrl = '{ld_prod: ld2, ld_sum: ld3, ld_out: ld4};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (ld2) begin
                r_v1 <= 1'b0;
            end
            if (ld2) begin
                r_v2 <= 1'b1;
            end else if (ld3) begin
                r_v2 <= 1'b0;
            end
            if (ld3) begin
                r_v3 <= 1'b1;
            end else if (ld4) begin
                r_v3 <= 1'b0;
            end
            if (ld4) begin
                r_v4 <= 1'b1;
            end else if (ldo) begin
                r_v4 <= 1'b0;
            end
            if (ldo) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // time runs backwards: count it as no time at all
    assign n_elapsed = (i_arrival_time >= r_prev_time) ? i_arrival_time - r_prev_time : '0;
    assign n_ge      = CMP_W'(i_arrival_time) >= CMP_W'(r_warmup);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_elapsed <= n_elapsed;
            r_len1    <= i_packet_length_bits;
            r_ge1     <= n_ge;
        end
        if (ld2) begin
            r_len2 <= r_len1;
            r_ge2  <= r_ge1;
        end
        if (ld3) begin
            r_len3 <= r_len2;
            r_ge3  <= r_ge2;
        end
        if (ld4) begin
            r_len4 <= r_len3;
            r_ge4  <= r_ge3;
        end
    end

    dtbm_refill #(
        .RATE_FRACTION_BITS (RATE_FRACTION_BITS),
        .TIME_WIDTH         (TIME_WIDTH)
    ) u_mean_refill (
        .i_clk     (i_clk),
        .i_ctrl    (refill_ctrl),
        .i_rate    (r_mean_rate),
        .i_elapsed (r_elapsed),
        .o_refill  (mean_refill)
    );

    dtbm_refill #(
        .RATE_FRACTION_BITS (RATE_FRACTION_BITS),
        .TIME_WIDTH         (TIME_WIDTH)
    ) u_peak_refill (
        .i_clk     (i_clk),
        .i_ctrl    (refill_ctrl),
        .i_rate    (r_peak_rate),
        .i_elapsed (r_elapsed),
        .o_refill  (peak_refill)
    );

    // refill, cap, test and debit both buckets
    always_comb begin
        mean_sum    = (REFILL_W + 1)'(r_mean_tokens) + (REFILL_W + 1)'(mean_refill);
        peak_sum    = (REFILL_W + 1)'(r_peak_tokens) + (REFILL_W + 1)'(peak_refill);
        mean_filled = (mean_sum > (REFILL_W + 1)'(r_bucket_size)) ? r_bucket_size
                                                                   : mean_sum[MEAN_W-1:0];
        peak_filled = (peak_sum > (REFILL_W + 1)'(r_mtu)) ? r_mtu : peak_sum[PEAK_W-1:0];
        conform     = (MEAN_W'(r_len4) <= mean_filled) && (r_len4 <= peak_filled);

        n_not_conformed = !conform;
        n_mean_tokens   = conform ? mean_filled - MEAN_W'(r_len4) : mean_filled;
        n_peak_tokens   = conform ? peak_filled - r_len4 : peak_filled;
        n_warm_done     = r_warm_done | r_ge4;

        bit_metered_sum   = (BIT_CNT_W + 1)'(r_bit_metered) + (BIT_CNT_W + 1)'(r_len4);
        bit_conformed_sum = (BIT_CNT_W + 1)'(r_bit_conformed) + (BIT_CNT_W + 1)'(r_len4);

        n_pkt_metered   = r_pkt_metered;
        n_pkt_conformed = r_pkt_conformed;
        n_bit_metered   = r_bit_metered;
        n_bit_conformed = r_bit_conformed;
        if (n_warm_done) begin
            n_pkt_metered = (&r_pkt_metered) ? r_pkt_metered : r_pkt_metered + 1'b1;
            n_bit_metered = bit_metered_sum[BIT_CNT_W] ? '1 : bit_metered_sum[BIT_CNT_W-1:0];
            if (conform) begin
                n_pkt_conformed = (&r_pkt_conformed) ? r_pkt_conformed
                                                     : r_pkt_conformed + 1'b1;
                n_bit_conformed = bit_conformed_sum[BIT_CNT_W] ? '1
                                                               : bit_conformed_sum[BIT_CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_size   <= MEAN_SIZE_RESET;
            r_mean_rate     <= '0;
            r_mtu           <= MTU_RESET;
            r_peak_rate     <= '0;
            r_warmup        <= '0;
            r_mean_tokens   <= MEAN_SIZE_RESET;
            r_peak_tokens   <= MTU_RESET;
            r_prev_time     <= '0;
            r_warm_done     <= 1'b0;
            r_pkt_metered   <= '0;
            r_pkt_conformed <= '0;
            r_bit_metered   <= '0;
            r_bit_conformed <= '0;
        end else begin
            if (cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_BUCKET_SIZE: begin
                        r_bucket_size <= i_cfg_data[MEAN_W-1:0];
                        r_mean_tokens <= i_cfg_data[MEAN_W-1:0];
                    end
                    CFG_MEAN_RATE: r_mean_rate <= i_cfg_data[RATE_W-1:0];
                    CFG_MTU: begin
                        r_mtu         <= i_cfg_data[PEAK_W-1:0];
                        r_peak_tokens <= i_cfg_data[PEAK_W-1:0];
                    end
                    CFG_PEAK_RATE: r_peak_rate <= i_cfg_data[RATE_W-1:0];
                    CFG_WARMUP:    r_warmup    <= i_cfg_data[WARMUP_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_prev_time <= i_arrival_time;
            end
            if (ldo) begin
                r_mean_tokens   <= n_mean_tokens;
                r_peak_tokens   <= n_peak_tokens;
                r_warm_done     <= n_warm_done;
                r_pkt_metered   <= n_pkt_metered;
                r_pkt_conformed <= n_pkt_conformed;
                r_bit_metered   <= n_bit_metered;
                r_bit_conformed <= n_bit_conformed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ldo) begin
            r_not_conformed <= n_not_conformed;
        end
    end

    // state holds until the next packet lands, so it doubles as the result
    assign o_out_valid         = r_out_valid;
    assign o_not_conformed     = r_not_conformed;
    assign o_mean_bucket_level = r_mean_tokens;
    assign o_peak_bucket_level = r_peak_tokens;
    assign o_packets_metered   = r_pkt_metered;
    assign o_packets_conformed = r_pkt_conformed;
    assign o_bits_metered      = r_bit_metered;
    assign o_bits_conformed    = r_bit_conformed;

endmodule
